>>> hdl/bbsf_pkg.sv
package bbsf_pkg;

    localparam int CMD_W    = 3;
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 7;
    localparam int CNT_W    = 11;
    localparam int TOTAL_W  = 32;

    localparam logic [CNT_W-1:0] CAP_RESET = 11'd1024;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 3'd0,
        CMD_END   = 3'd1,
        CMD_PEEK  = 3'd2,
        CMD_READ  = 3'd3,
        CMD_POP   = 3'd4
    } t_cmd_code;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  length;
    } t_cmd;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic               byte_valid;
        logic               last_of_run;
        logic               write_accepted;
        logic               error_flag;
        logic [CNT_W-1:0]   stored_count;
        logic [CNT_W-1:0]   space_left;
        logic [TOTAL_W-1:0] total_written;
        logic [TOTAL_W-1:0] total_read;
        logic               input_closed;
        logic               end_of_stream;
    } t_res;

    // Request from the command decoder to the run sequencer.
    typedef struct packed {
        logic start;
        logic single;
        logic accepted;
    } t_run_ctl;

endpackage

>>> hdl/bbsf_chan.sv
interface bbsf_chan #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> hdl/bounded_byte_stream_fifo_top.sv
// Bounded byte stream FIFO.
// Commands arrive on i_cmd (valid/ready); each transfer carries one command:
// write a byte, end input, peek n, read n or pop n bytes. Results leave on
// o_res (valid/ready); every result carries the status after the whole
// command. i_cfg_we with i_cfg_data sets the capacity limit; the user must
// write it only while idle; the block itself does not enforce this. A write,
// end input, pop, failed read or unknown code gives one result in the output
// register in the cycle after its transfer; such commands follow at one per
// cycle while the receiver takes every result. A peek or read streams its n
// bytes from the byte memory via its read register to the output register
// at one per cycle, a rate set by its single read port, while nothing stalls.
// The next command is taken once the last result of a run is transferred.
// When the receiver stalls, the output register and the held memory read
// data keep every byte, and reads from the memory pause.
// Reset clears counters, pointers and flags and sets the capacity to 1024;
// the byte memory is not cleared, as only written entries are ever read.
module bounded_byte_stream_fifo_top #(
    parameter int DEPTH   = 1024,
    parameter int MAX_RUN = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [bbsf_pkg::CNT_W-1:0] i_cfg_data,
    bbsf_chan.sink                    i_cmd,
    bbsf_chan.source                  o_res
);

    localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCW = $clog2(DEPTH + 1);
    localparam int CW  = (OCW > bbsf_pkg::CNT_W) ? OCW : bbsf_pkg::CNT_W;
    localparam int RW  = $clog2(MAX_RUN + 1);
    localparam logic [CW:0]   DEPTH_W   = (CW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);
    localparam logic [RW-1:0] MAX_RUN_R = RW'(MAX_RUN);

    // Architectural state kept in registers; the bytes live in the memory.
    logic [AW-1:0]                r_head;
    logic [CW-1:0]                r_occ;
    logic [bbsf_pkg::TOTAL_W-1:0] r_wtot;
    logic [bbsf_pkg::TOTAL_W-1:0] r_rtot;
    logic                         r_ended;
    logic                         r_err;
    logic [bbsf_pkg::CNT_W-1:0]   r_cap;

    logic [AW-1:0]                n_head;
    logic [CW-1:0]                n_occ;
    logic [bbsf_pkg::TOTAL_W-1:0] n_wtot;
    logic [bbsf_pkg::TOTAL_W-1:0] n_rtot;
    logic                         n_ended;
    logic                         n_err;

    bbsf_pkg::t_cmd     cmd;
    bbsf_pkg::t_run_ctl ctl;
    logic               accept;
    logic               cmd_ready;
    logic [RW-1:0]      run_len;
    logic [RW-1:0]      n_sat;
    logic [CW-1:0]      n_ext;
    logic [CW-1:0]      cap_ext;
    logic [CW-1:0]      eff_cap;
    logic [CW-1:0]      space;
    logic [CW:0]        wsum;
    logic [CW:0]        hsum;
    logic [AW-1:0]      waddr;
    logic [AW-1:0]      head_adv;
    logic               ram_we;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [bbsf_pkg::BYTE_W-1:0] rd_data;
    logic               out_valid;
    logic [bbsf_pkg::BYTE_W-1:0] out_byte;
    logic               byte_valid;
    logic               out_last;
    logic               out_acc;

    assign cmd         = i_cmd.payload;
    assign i_cmd.ready = cmd_ready;
    assign accept      = i_cmd.valid && cmd_ready;

    // Length saturates at the longest run; capacity saturates at the memory size.
    assign n_sat   = (cmd.length > bbsf_pkg::LEN_W'(MAX_RUN)) ? MAX_RUN_R : RW'(cmd.length);
    assign n_ext   = CW'(n_sat);
    assign cap_ext = CW'(r_cap);
    assign eff_cap = (cap_ext > DEPTH_C) ? DEPTH_C : cap_ext;
    assign space   = (eff_cap > r_occ) ? eff_cap - r_occ : '0;

    // Both sums stay below twice the depth, so one conditional subtract wraps them.
    assign wsum     = (CW + 1)'(r_head) + (CW + 1)'(r_occ);
    assign waddr    = AW'((wsum >= DEPTH_W) ? wsum - DEPTH_W : wsum);
    assign hsum     = (CW + 1)'(r_head) + (CW + 1)'(n_ext);
    assign head_adv = AW'((hsum >= DEPTH_W) ? hsum - DEPTH_W : hsum);

    always_comb begin
        n_head       = r_head;
        n_occ        = r_occ;
        n_wtot       = r_wtot;
        n_rtot       = r_rtot;
        n_ended      = r_ended;
        n_err        = r_err;
        ram_we       = 1'b0;
        run_len      = n_sat;
        ctl.start    = accept;
        ctl.single   = 1'b1;
        ctl.accepted = 1'b0;
        unique case (cmd.command) inside
            bbsf_pkg::CMD_WRITE: begin
                if (r_occ < eff_cap) begin
                    ram_we       = accept;
                    ctl.accepted = 1'b1;
                    n_occ        = r_occ + 1'b1;
                    n_wtot       = r_wtot + 1'b1;
                end
            end
            bbsf_pkg::CMD_END: begin
                n_ended = 1'b1;
            end
            bbsf_pkg::CMD_PEEK: begin
                // Peek delivers what is there, up to the requested count.
                run_len    = (r_occ < n_ext) ? RW'(r_occ) : n_sat;
                ctl.single = (run_len == '0);
            end
            bbsf_pkg::CMD_READ, bbsf_pkg::CMD_POP: begin
                if (n_ext > r_occ) begin
                    n_err = 1'b1;
                end else begin
                    n_head     = head_adv;
                    n_occ      = r_occ - n_ext;
                    n_rtot     = r_rtot + bbsf_pkg::TOTAL_W'(n_sat);
                    ctl.single = (cmd.command == bbsf_pkg::CMD_POP) || (n_sat == '0);
                end
            end
            default: begin
                ctl.single = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_occ   <= '0;
            r_wtot  <= '0;
            r_rtot  <= '0;
            r_ended <= 1'b0;
            r_err   <= 1'b0;
            r_cap   <= bbsf_pkg::CAP_RESET;
        end else begin
            if (accept) begin
                r_head  <= n_head;
                r_occ   <= n_occ;
                r_wtot  <= n_wtot;
                r_rtot  <= n_rtot;
                r_ended <= n_ended;
                r_err   <= n_err;
            end
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    bbsf_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (waddr),
        .i_wdata (cmd.data_byte),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Runs start at the head as it was before the command; the head register
    // already points past a read when its bytes stream out.
    bbsf_seq #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .RW    (RW)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .i_base       (r_head),
        .i_count      (run_len),
        .o_cmd_ready  (cmd_ready),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data),
        .o_out_valid  (out_valid),
        .i_out_ready  (o_res.ready),
        .o_out_byte   (out_byte),
        .o_byte_valid (byte_valid),
        .o_last       (out_last),
        .o_accepted   (out_acc)
    );

    // Status comes straight from the state registers, which change only on a
    // capacity write or command transfer; a transfer waits for any pending result.
    assign o_res.valid                  = out_valid;
    assign o_res.payload.out_byte       = out_byte;
    assign o_res.payload.byte_valid     = byte_valid;
    assign o_res.payload.last_of_run    = out_last;
    assign o_res.payload.write_accepted = out_acc;
    assign o_res.payload.error_flag     = r_err;
    assign o_res.payload.stored_count   = r_occ[bbsf_pkg::CNT_W-1:0];
    assign o_res.payload.space_left     = space[bbsf_pkg::CNT_W-1:0];
    assign o_res.payload.total_written  = r_wtot;
    assign o_res.payload.total_read     = r_rtot;
    assign o_res.payload.input_closed   = r_ended;
    assign o_res.payload.end_of_stream  = r_ended && (r_occ == '0);

    // The fill level never goes past the memory size.
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= DEPTH_C)
        else $error("fill level above memory size");

    // A byte write never lands while a run is reading the memory.
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> !rd_en)
        else $error("memory write during a run");

    // The error flag holds until reset.
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |=> r_err)
        else $error("sticky error cleared");

    // Bytes delivered by a run always come with byte_valid set.
    a_run_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !out_last) |-> byte_valid)
        else $error("run result without a byte");

endmodule

>>> hdl/bbsf_ram.sv
module bbsf_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [bbsf_pkg::BYTE_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [AW-1:0]              i_raddr,
    output logic [bbsf_pkg::BYTE_W-1:0] o_rdata
);

    logic [bbsf_pkg::BYTE_W-1:0] r_mem [DEPTH];
    logic [bbsf_pkg::BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds its value until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/bbsf_seq.sv
module bbsf_seq #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int RW    = 7
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bbsf_pkg::t_run_ctl          i_ctl,
    input  logic [AW-1:0]               i_base,
    input  logic [RW-1:0]               i_count,
    output logic                        o_cmd_ready,
    output logic                        o_rd_en,
    output logic [AW-1:0]               o_rd_addr,
    input  logic [bbsf_pkg::BYTE_W-1:0] i_rd_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [bbsf_pkg::BYTE_W-1:0] o_out_byte,
    output logic                        o_byte_valid,
    output logic                        o_last,
    output logic                        o_accepted
);

    typedef enum logic {
        ST_IDLE,
        ST_STREAM
    } t_state;

    t_state                      r_state;
    logic [AW-1:0]               r_addr;
    logic [RW-1:0]               r_rem;
    logic                        r_q_vld;
    logic                        r_q_last;
    logic                        r_o_vld;
    logic [bbsf_pkg::BYTE_W-1:0] r_o_byte;
    logic                        r_o_bvld;
    logic                        r_o_last;
    logic                        r_o_acc;

    logic out_free;
    logic consume;
    logic issue;
    logic load_out;

    // The memory output acts as a one-entry buffer in front of the output register.
    assign out_free    = !r_o_vld || i_out_ready;
    assign consume     = r_q_vld && out_free;
    assign issue       = (r_state == ST_STREAM) && (r_rem != '0) && (!r_q_vld || consume);
    assign o_cmd_ready = (r_state == ST_IDLE) && out_free;
    assign o_rd_en     = issue;
    assign o_rd_addr   = r_addr;
    // The output register takes a new result this cycle.
    assign load_out    = ((r_state == ST_IDLE) && i_ctl.start && i_ctl.single) ||
                         ((r_state == ST_STREAM) && consume);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rem   <= '0;
            r_q_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (r_o_vld && i_out_ready && !load_out) begin
                r_o_vld <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_ctl.start) begin
                        if (i_ctl.single) begin
                            r_o_vld  <= 1'b1;
                            r_o_byte <= '0;
                            r_o_bvld <= 1'b0;
                            r_o_last <= 1'b1;
                            r_o_acc  <= i_ctl.accepted;
                        end else begin
                            r_state <= ST_STREAM;
                            r_addr  <= i_base;
                            r_rem   <= i_count;
                        end
                    end
                end
                ST_STREAM: begin
                    if (issue) begin
                        r_addr   <= (r_addr == AW'(DEPTH - 1)) ? '0 : r_addr + 1'b1;
                        r_rem    <= r_rem - 1'b1;
                        r_q_vld  <= 1'b1;
                        r_q_last <= (r_rem == RW'(1));
                    end else if (consume) begin
                        r_q_vld <= 1'b0;
                    end
                    if (consume) begin
                        r_o_vld  <= 1'b1;
                        r_o_byte <= i_rd_data;
                        r_o_bvld <= 1'b1;
                        r_o_last <= r_q_last;
                        r_o_acc  <= 1'b0;
                        if (r_q_last) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid  = r_o_vld;
    assign o_out_byte   = r_o_byte;
    assign o_byte_valid = r_o_bvld;
    assign o_last       = r_o_last;
    assign o_accepted   = r_o_acc;

endmodule

>>> tb/bbsf_checker.sv
`timescale 1ns / 100ps

// Watches the command and result channels and the capacity write port, keeps
// its own model of the byte FIFO, and compares every result transfer with
// the oldest predicted result.
module bbsf_checker #(
    parameter int DEPTH        = 1024,
    parameter int MAX_RUN      = 64,
    parameter int REPORT_LIMIT = 10
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [bbsf_pkg::CNT_W-1:0] i_cfg_data,
    input  logic                       i_cmd_valid,
    input  logic                       i_cmd_ready,
    input  bbsf_pkg::t_cmd             i_cmd_payload,
    input  logic                       i_res_valid,
    input  logic                       i_res_ready,
    input  bbsf_pkg::t_res             i_res_payload,
    output int                         o_fail_count,
    output int                         o_pending
);

    logic [bbsf_pkg::BYTE_W-1:0]  fifo_mem [DEPTH];
    int unsigned                  head_idx;
    logic [bbsf_pkg::CNT_W-1:0]   fill_level;
    logic [bbsf_pkg::TOTAL_W-1:0] bytes_in;
    logic [bbsf_pkg::TOTAL_W-1:0] bytes_out;
    logic                         closed;
    logic                         err_seen;
    logic [bbsf_pkg::CNT_W-1:0]   cap_reg;
    bbsf_pkg::t_res               expected_results [$];
    int                           mismatches;

    function automatic logic [bbsf_pkg::CNT_W-1:0] usable_capacity();
        return (cap_reg > DEPTH) ? bbsf_pkg::CNT_W'(DEPTH) : cap_reg;
    endfunction

    // Status as seen after the whole command, with the per-result fields.
    function automatic bbsf_pkg::t_res status_word(input logic [bbsf_pkg::BYTE_W-1:0] b,
                                                   input logic v, input logic last,
                                                   input logic acc);
        bbsf_pkg::t_res             r;
        logic [bbsf_pkg::CNT_W-1:0] cap;
        cap              = usable_capacity();
        r.out_byte       = v ? b : '0;
        r.byte_valid     = v;
        r.last_of_run    = last;
        r.write_accepted = acc;
        r.error_flag     = err_seen;
        r.stored_count   = fill_level;
        r.space_left     = (cap > fill_level) ? cap - fill_level : '0;
        r.total_written  = bytes_in;
        r.total_read     = bytes_out;
        r.input_closed   = closed;
        r.end_of_stream  = closed && (fill_level == 0);
        return r;
    endfunction

    // Appends one predicted result at the tail of the queue.
    function automatic void queue_result(input bbsf_pkg::t_res r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    task automatic model_command(input bbsf_pkg::t_cmd c);
        int unsigned n;
        int unsigned cnt;
        int unsigned old_head;
        logic        ok;
        n  = (c.length > MAX_RUN) ? MAX_RUN : c.length;
        ok = 1'b0;
        case (c.command)
            bbsf_pkg::CMD_WRITE: begin
                if (fill_level < usable_capacity()) begin
                    fifo_mem[(head_idx + fill_level) % DEPTH] = c.data_byte;
                    fill_level = fill_level + 1'b1;
                    bytes_in   = bytes_in + 1'b1;
                    ok         = 1'b1;
                end
                queue_result(status_word('0, 1'b0, 1'b1, ok));
            end
            bbsf_pkg::CMD_END: begin
                closed = 1'b1;
                queue_result(status_word('0, 1'b0, 1'b1, 1'b0));
            end
            bbsf_pkg::CMD_PEEK: begin
                cnt = (n < fill_level) ? n : fill_level;
                if (cnt == 0) begin
                    queue_result(status_word('0, 1'b0, 1'b1, 1'b0));
                end else begin
                    for (int i = 0; i < cnt; i++) begin
                        queue_result(status_word(
                            fifo_mem[(head_idx + i) % DEPTH], 1'b1, i + 1 == cnt, 1'b0));
                    end
                end
            end
            bbsf_pkg::CMD_READ, bbsf_pkg::CMD_POP: begin
                if (n > fill_level) begin
                    err_seen = 1'b1;
                    queue_result(status_word('0, 1'b0, 1'b1, 1'b0));
                end else begin
                    // The bytes stay in memory after the head moves past them.
                    old_head   = head_idx;
                    head_idx   = (head_idx + n) % DEPTH;
                    fill_level = fill_level - bbsf_pkg::CNT_W'(n);
                    bytes_out  = bytes_out + n;
                    if (c.command == bbsf_pkg::CMD_POP || n == 0) begin
                        queue_result(status_word('0, 1'b0, 1'b1, 1'b0));
                    end else begin
                        for (int i = 0; i < n; i++) begin
                            queue_result(status_word(
                                fifo_mem[(old_head + i) % DEPTH], 1'b1, i + 1 == n, 1'b0));
                        end
                    end
                end
            end
            default: begin
                queue_result(status_word('0, 1'b0, 1'b1, 1'b0));
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [bbsf_pkg::TOTAL_W-1:0] want,
                               input logic [bbsf_pkg::TOTAL_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $realtime, name,
                         want, got);
            end
        end
    endtask

    task automatic compare_result(input bbsf_pkg::t_res got);
        bbsf_pkg::t_res want;
        if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("%0t: unexpected result 0x%0h", $realtime, got);
            end
        end else begin
            want = expected_results.pop_front();
            check_field("out_byte", want.out_byte, got.out_byte);
            check_field("byte_valid", want.byte_valid, got.byte_valid);
            check_field("last_of_run", want.last_of_run, got.last_of_run);
            check_field("write_accepted", want.write_accepted, got.write_accepted);
            check_field("error_flag", want.error_flag, got.error_flag);
            check_field("stored_count", want.stored_count, got.stored_count);
            check_field("space_left", want.space_left, got.space_left);
            check_field("total_written", want.total_written, got.total_written);
            check_field("total_read", want.total_read, got.total_read);
            check_field("input_closed", want.input_closed, got.input_closed);
            check_field("end_of_stream", want.end_of_stream, got.end_of_stream);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            head_idx   = 0;
            fill_level = '0;
            bytes_in   = '0;
            bytes_out  = '0;
            closed     = 1'b0;
            err_seen   = 1'b0;
            cap_reg    = bbsf_pkg::CAP_RESET;
            mismatches = 0;
            expected_results.delete();
        end else begin
            // A result always belongs to an earlier command, so compare first.
            if (i_res_valid && i_res_ready) begin
                compare_result(i_res_payload);
            end
            if (i_cfg_we) begin
                cap_reg = i_cfg_data;
            end
            if (i_cmd_valid && i_cmd_ready) begin
                model_command(i_cmd_payload);
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_results.size();
    end

endmodule

>>> tb/bounded_byte_stream_fifo_top_tb.sv
`timescale 1ns / 100ps

// Regression bench for the bounded byte stream FIFO. The top only makes
// stimulus: a short directed sequence, then five random phases that each
// run under a different capacity and one of four idling patterns. All
// prediction and comparison lives in the checker instantiated beside the
// block; the top turns its failure count into the verdict.
module bounded_byte_stream_fifo_top_tb;

    localparam int RESET_CYCLES     = 9;
    localparam int RANDOM_PER_PHASE = 64;
    // This covers the tail of any run of up to 64 bytes before the capacity
    // is rewritten or the verdict is given.
    localparam int DRAIN_CYCLES     = 100;
    // Cycles without any transfer before the run is declared hung.
    localparam int QUIET_LIMIT      = 2000;
    // Command codes with no meaning; the block must answer them with status.
    localparam int UNUSED_CODE_LO   = 5;
    localparam int UNUSED_CODE_HI   = 7;
    localparam int MAX_LENGTH       = 127;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [bbsf_pkg::CNT_W-1:0] cfg_data;
    int                         send_idle_pct;
    int                         stall_pct;
    int                         quiet_cycles;
    int                         fail_count;
    int                         pending;

    bbsf_chan #(.T(bbsf_pkg::t_cmd)) cmd_ch ();
    bbsf_chan #(.T(bbsf_pkg::t_res)) res_ch ();

    bounded_byte_stream_fifo_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_cmd      (cmd_ch),
        .o_res      (res_ch)
    );

    bbsf_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (cfg_data),
        .i_cmd_valid   (cmd_ch.valid),
        .i_cmd_ready   (cmd_ch.ready),
        .i_cmd_payload (cmd_ch.payload),
        .i_res_valid   (res_ch.valid),
        .i_res_ready   (res_ch.ready),
        .i_res_payload (res_ch.payload),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // The clock starts low so that the first rising edge comes after the
    // initial values below have settled.
    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // The receiver drops ready at random according to the current phase.
    // One nonblocking update per edge keeps ready free of glitches.
    always @(posedge clk) begin
        res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // The watchdog restarts whenever a transfer happens on either channel.
    // A hung block therefore ends the run with a failure instead of looping.
    always @(posedge clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("bounded_byte_stream_fifo_top regression: fail");
            $finish;
        end
    end

    function automatic bbsf_pkg::t_cmd make_cmd(input logic [bbsf_pkg::CMD_W-1:0] code,
                                                input logic [bbsf_pkg::BYTE_W-1:0] data,
                                                input int len);
        bbsf_pkg::t_cmd c;
        c.command   = code;
        c.data_byte = data;
        c.length    = bbsf_pkg::LEN_W'(len);
        return c;
    endfunction

    // Random commands favor writes so that the FIFO fills up, and keep most
    // lengths small so that reads and pops usually find enough bytes. The
    // last branch asks for long runs, which saturate or overrun.
    function automatic bbsf_pkg::t_cmd random_command();
        bbsf_pkg::t_cmd c;
        int             pick;
        pick        = $urandom_range(0, 99);
        c.data_byte = bbsf_pkg::BYTE_W'($urandom_range(0, 255));
        c.length    = bbsf_pkg::LEN_W'($urandom_range(0, 6));
        if (pick < 45) begin
            c.command = bbsf_pkg::CMD_WRITE;
        end else if (pick < 60) begin
            c.command = bbsf_pkg::CMD_PEEK;
        end else if (pick < 75) begin
            c.command = bbsf_pkg::CMD_READ;
        end else if (pick < 85) begin
            c.command = bbsf_pkg::CMD_POP;
        end else if (pick < 89) begin
            c.command = bbsf_pkg::CMD_END;
        end else if (pick < 93) begin
            c.command = bbsf_pkg::CMD_W'($urandom_range(UNUSED_CODE_LO, UNUSED_CODE_HI));
        end else begin
            c.command = bbsf_pkg::CMD_W'($urandom_range(bbsf_pkg::CMD_PEEK,
                                                        bbsf_pkg::CMD_POP));
            c.length  = bbsf_pkg::LEN_W'($urandom_range(0, MAX_LENGTH));
        end
        return c;
    endfunction

    // Offers one command and returns at the edge where it is transferred.
    // Valid stays high afterwards, so back-to-back commands need no extra
    // assignment; an idle gap lowers it with the first idle cycle.
    task automatic send_command(input bbsf_pkg::t_cmd c);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.payload <= c;
        do begin
            @(posedge clk);
        end while (!(cmd_ch.valid && cmd_ch.ready));
    endtask

    // Stops offering commands, waits until every predicted result has been
    // transferred, then lets the block finish whatever run is still in flight.
    task automatic wait_idle();
        cmd_ch.valid <= 1'b0;
        do begin
            @(posedge clk);
        end while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input logic [bbsf_pkg::CNT_W-1:0] cap, input int idle_pct,
                             input int stall);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= cap;
        @(posedge clk);
        cfg_we        <= 1'b0;
        send_idle_pct  = idle_pct;
        stall_pct      = stall;
        repeat (RANDOM_PER_PHASE) send_command(random_command());
    endtask

    initial begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_data       = '0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.payload = '0;
        res_ch.ready   = 1'b0;
        quiet_cycles   = 0;
        send_idle_pct  = 0;
        stall_pct      = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, under the reset capacity and without idling.
        // A peek of an empty FIFO gives one status result.
        send_command(make_cmd(bbsf_pkg::CMD_PEEK, 8'h00, 0));
        // Eight writes with the byte extremes and alternating bit patterns.
        send_command(make_cmd(bbsf_pkg::CMD_WRITE, 8'h00, 0));
        send_command(make_cmd(bbsf_pkg::CMD_WRITE, 8'hFF, 0));
        send_command(make_cmd(bbsf_pkg::CMD_WRITE, 8'hA5, 0));
        send_command(make_cmd(bbsf_pkg::CMD_WRITE, 8'h5A, 0));
        send_command(make_cmd(bbsf_pkg::CMD_WRITE, 8'h01, 0));
        send_command(make_cmd(bbsf_pkg::CMD_WRITE, 8'h80, 0));
        send_command(make_cmd(bbsf_pkg::CMD_WRITE, 8'h7F, 0));
        send_command(make_cmd(bbsf_pkg::CMD_WRITE, 8'h3C, 0));
        // A short peek, then the largest length, which saturates and is
        // further cut to the stored count.
        send_command(make_cmd(bbsf_pkg::CMD_PEEK, 8'h00, 3));
        send_command(make_cmd(bbsf_pkg::CMD_PEEK, 8'hFF, MAX_LENGTH));
        // A read of zero bytes succeeds and gives one status result.
        send_command(make_cmd(bbsf_pkg::CMD_READ, 8'h00, 0));
        send_command(make_cmd(bbsf_pkg::CMD_READ, 8'h00, 2));
        send_command(make_cmd(bbsf_pkg::CMD_POP, 8'h00, 1));
        // Every unused command code is answered with plain status.
        for (int code = UNUSED_CODE_LO; code <= UNUSED_CODE_HI; code++) begin
            send_command(make_cmd(bbsf_pkg::CMD_W'(code), 8'h00, 0));
        end
        // Closing the input does not block later writes.
        send_command(make_cmd(bbsf_pkg::CMD_END, 8'h00, 0));
        send_command(make_cmd(bbsf_pkg::CMD_WRITE, 8'h99, 0));
        send_command(make_cmd(bbsf_pkg::CMD_PEEK, 8'h00, 64));
        // Drain the FIFO so that end of stream shows up.
        send_command(make_cmd(bbsf_pkg::CMD_READ, 8'h00, 5));
        send_command(make_cmd(bbsf_pkg::CMD_POP, 8'h00, 1));
        // Over-length read and pop set the sticky error and move nothing.
        send_command(make_cmd(bbsf_pkg::CMD_READ, 8'h00, 1));
        send_command(make_cmd(bbsf_pkg::CMD_POP, 8'h00, 64));
        send_command(make_cmd(bbsf_pkg::CMD_PEEK, 8'h00, 1));

        // Random phases. A small capacity fills quickly; a capacity of one
        // then sits below the fill level left over; zero refuses every
        // write; 2047 saturates at the depth; 1024 is the full depth.
        run_phase(bbsf_pkg::CNT_W'(12), 0, 0);
        run_phase(bbsf_pkg::CNT_W'(1), 65, 0);
        run_phase(bbsf_pkg::CNT_W'(0), 0, 65);
        run_phase(bbsf_pkg::CNT_W'(2047), 27, 27);
        run_phase(bbsf_pkg::CNT_W'(1024), 0, 0);

        wait_idle();
        if (fail_count == 0 && pending == 0) begin
            $display("bounded_byte_stream_fifo_top regression: pass");
        end else begin
            $display("bounded_byte_stream_fifo_top regression: fail");
        end
        $finish;
    end

endmodule
